>>> rtl/core/pds_pkg.sv
// Shared types and constants of the PLL divider search.
// Used by pds_eval and pll_divider_search; depends on nothing.
package pds_pkg;

    localparam int REF_W = 30;
    localparam int TGT_W = 32;
    localparam int OUT_W = 176;

    localparam logic [63:0] PFD_MIN = 64'd5000000;
    localparam logic [63:0] PFD_MAX = 64'd200000000;
    localparam logic [63:0] VCO_MIN = 64'd1800000000;
    localparam logic [63:0] VCO_MAX = 64'd3800000000;
    localparam logic [29:0] REF_MIN = 30'd5000000;
    localparam logic [29:0] REF_MAX = 30'd900000000;
    localparam logic [31:0] TGT_MIN = 32'd47368000;
    localparam logic [31:0] TGT_MAX = 32'd3800000000;
    localparam logic [29:0] REF_RESET = 30'd100000000;

    localparam logic [27:0] R0_BASE = 28'h4000000;
    localparam logic [27:0] R1_BASE = 28'hC400200;
    localparam logic [27:0] R3_BASE = 28'h2000FBA;
    localparam logic [27:0] R5_BASE = 28'h0000A00;

    // Status reported by the evaluation pipeline to the sequencer.
    typedef struct packed {
        logic done;
        logic busy;
    } eval_stat_t;

    function automatic logic [2:0] band_code(input logic [29:0] f);
        logic [2:0] code;
        if (f < 30'd64000000)       code = 3'd0;
        else if (f < 30'd128000000) code = 3'd1;
        else if (f < 30'd256000000) code = 3'd2;
        else if (f < 30'd512000000) code = 3'd3;
        else                        code = 3'd4;
        return code;
    endfunction

endpackage

>>> rtl/core/pds_eval.sv
// Candidate evaluation pipeline: three register stages, then the best-error commit.
// Depends on pds_pkg.
module pds_eval #(
    parameter int RW  = 8,
    parameter int NW  = 12,
    parameter int DW  = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [31:0]           target,
    input  logic                  cand_valid,
    input  logic [RW-1:0]         cand_r,
    input  logic [NW-1:0]         cand_n,
    input  logic [DW-1:0]         cand_d,
    input  logic [30+NW-1:0]      cand_fn,
    output pds_pkg::eval_stat_t   stat,
    output logic [RW-1:0]         best_r,
    output logic [NW-1:0]         best_n,
    output logic [DW-1:0]         best_d
);
    localparam int FNW  = 30 + NW;
    localparam int DENW = RW + DW;
    localparam int TRW  = 32 + DENW;
    localparam int EW   = (FNW > TRW) ? FNW : TRW;
    localparam int PRW  = EW + DENW;

    logic            v1_reg, v2_reg, v3_reg;
    logic [RW-1:0]   r1_reg, r2_reg, r3_reg;
    logic [NW-1:0]   n1_reg, n2_reg, n3_reg;
    logic [DW-1:0]   d1_reg, d2_reg, d3_reg;
    logic [FNW-1:0]  fn1_reg, fn2_reg;
    logic [DENW-1:0] den1_reg, den2_reg, den3_reg;
    logic [TRW-1:0]  tr2_reg;
    logic [EW-1:0]   num3_reg;
    logic [EW-1:0]   knum_reg, knum_next;
    logic [DENW-1:0] kden_reg, kden_next;
    logic [RW-1:0]   br_reg;
    logic [NW-1:0]   bn_reg;
    logic [DW-1:0]   bd_reg;
    logic            done_reg;
    logic [PRW-1:0]  lhs, rhs;
    logic            better;
    logic [EW-1:0]   fn_x, tr_x;

    assign fn_x = EW'(fn2_reg);
    assign tr_x = EW'(tr2_reg);

    // The error of a candidate is num/den; cross-multiply against the kept one.
    assign lhs       = PRW'(num3_reg) * PRW'(kden_reg);
    assign rhs       = PRW'(knum_reg) * PRW'(den3_reg);
    assign better    = lhs < rhs;
    assign knum_next = better ? num3_reg : knum_reg;
    assign kden_next = better ? den3_reg : kden_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
            br_reg   <= '0;
            bn_reg   <= '0;
            bd_reg   <= '0;
            knum_reg <= '0;
            kden_reg <= '0;
        end
        else if (start)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
            br_reg   <= '0;
            bn_reg   <= '0;
            bd_reg   <= '0;
            knum_reg <= EW'(target);
            kden_reg <= DENW'(1);
        end
        else
        begin
            v1_reg <= cand_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v3_reg && !done_reg)
            begin
                knum_reg <= knum_next;
                kden_reg <= kden_next;
                if (better)
                begin
                    br_reg <= r3_reg;
                    bn_reg <= n3_reg;
                    bd_reg <= d3_reg;
                end
                done_reg <= knum_next < EW'(kden_next);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r1_reg   <= cand_r;
        n1_reg   <= cand_n;
        d1_reg   <= cand_d;
        fn1_reg  <= cand_fn;
        den1_reg <= DENW'(cand_r) * DENW'(cand_d);
        r2_reg   <= r1_reg;
        n2_reg   <= n1_reg;
        d2_reg   <= d1_reg;
        fn2_reg  <= fn1_reg;
        den2_reg <= den1_reg;
        tr2_reg  <= TRW'(target) * TRW'(den1_reg);
        r3_reg   <= r2_reg;
        n3_reg   <= n2_reg;
        d3_reg   <= d2_reg;
        den3_reg <= den2_reg;
        num3_reg <= (fn_x >= tr_x) ? (fn_x - tr_x) : (tr_x - fn_x);
    end

    assign stat.done = done_reg;
    assign stat.busy = v1_reg | v2_reg | v3_reg;
    assign best_r    = br_reg;
    assign best_n    = bn_reg;
    assign best_d    = bd_reg;

endmodule

>>> rtl/core/pds_div.sv
// Restoring divider, one quotient bit per cycle, for the achieved frequency.
// Depends on nothing.
module pds_div #(
    parameter int NUMW = 42,
    parameter int DENW = 14
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic            done,
    output logic [NUMW-1:0] quo
);
    localparam int CW = $clog2(NUMW + 1);

    logic [DENW-1:0] den_reg;
    logic [DENW:0]   rem_reg;
    logic [NUMW-1:0] quo_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg, done_reg;
    logic [DENW:0]   trial;
    logic            fits;

    assign trial = {rem_reg[DENW-1:0], quo_reg[NUMW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUMW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[NUMW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> rtl/core/pll_divider_search.sv
// Top level of the PLL divider search: sequencer, result formatting, ports.
// Depends on pds_pkg, pds_eval and pds_div.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata[31:0] target_freq_hz
//  m_axis    | out       | tuser[0] status, tdata fields as listed at the port
//  cfg       | in        | cfg_wr_data[29:0] ref_freq_hz
//
// An out-of-range request goes straight to a failure result. Otherwise the
// sequencer steps through the skipped R or N values and the visited (R, N, D)
// triples; once the evaluation pipeline has drained, the serial divider computes
// the achieved frequency if a candidate was found.
// Reset loads the reference of 100 MHz; no memory needs clearing.
// A stalled result holds in the output register; a new word is taken meanwhile.
module pll_divider_search #(
    parameter int R_MAX = 255,
    parameter int N_MAX = 4095,
    parameter int D_MAX = 38
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [29:0]                 cfg_wr_data,     // ref_freq_hz
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,    // target_freq_hz
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // r_div, n_div, d_div, achieved_freq_hz, word_r0, word_r1, word_r3, word_r5
    output logic [pds_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic [0:0]                  m_axis_tuser     // status
);
    localparam int RW   = $clog2(R_MAX + 1);
    localparam int NW   = $clog2(N_MAX + 1);
    localparam int DW   = $clog2(D_MAX + 1);
    localparam int FNW  = 30 + NW;
    localparam int DENW = RW + DW;
    localparam int PW   = 28 + RW;
    localparam int VW   = 32 + RW;
    localparam int MW   = (FNW > VW) ? FNW : VW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIVIDE,
        ST_FINAL
    } state_t;

    state_t             state_reg;
    logic [29:0]        ref_reg;
    logic [31:0]        tgt_reg;
    logic [RW-1:0]      r_reg;
    logic [NW-1:0]      n_reg;
    logic [DW-1:0]      d_reg;
    logic               seq_end_reg;
    logic               fail_reg;
    logic [31:0]        ach_reg;
    logic               out_valid_reg;
    logic [pds_pkg::OUT_W-1:0] tdata_reg;
    logic [0:0]         tuser_reg;

    logic               accept, in_range, start;
    logic [31:0]        eval_tgt;
    logic [PW-1:0]      pfd_min_r, pfd_max_r;
    logic [VW-1:0]      vco_min_r, vco_max_r;
    logic [FNW-1:0]     fn_cur;
    logic               pfd_bad, vco_bad, issue;
    pds_pkg::eval_stat_t stat;
    logic [RW-1:0]      best_r;
    logic [NW-1:0]      best_n;
    logic [DW-1:0]      best_d;
    logic               div_start, div_done;
    logic [FNW-1:0]     div_quo;
    logic               out_free, out_load;
    logic [27:0]        w_r0, w_r1, w_r3, w_r5;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign in_range = ref_reg >= pds_pkg::REF_MIN && ref_reg <= pds_pkg::REF_MAX
                   && s_axis_tdata >= pds_pkg::TGT_MIN && s_axis_tdata <= pds_pkg::TGT_MAX;
    assign start    = accept && in_range;

    // The evaluator sees the incoming word at the start and the held target after.
    assign eval_tgt = (state_reg == ST_IDLE) ? s_axis_tdata : tgt_reg;

    assign pfd_min_r = PW'(pds_pkg::PFD_MIN) * PW'(r_reg);
    assign pfd_max_r = PW'(pds_pkg::PFD_MAX) * PW'(r_reg);
    assign vco_min_r = VW'(pds_pkg::VCO_MIN) * VW'(r_reg);
    assign vco_max_r = VW'(pds_pkg::VCO_MAX) * VW'(r_reg);
    assign fn_cur    = FNW'(ref_reg) * FNW'(n_reg);
    assign pfd_bad   = PW'(ref_reg) < pfd_min_r || PW'(ref_reg) > pfd_max_r;
    assign vco_bad   = MW'(fn_cur) < MW'(vco_min_r) || MW'(fn_cur) > MW'(vco_max_r);
    assign issue     = state_reg == ST_SEARCH && !seq_end_reg && !stat.done
                    && !pfd_bad && !vco_bad;

    assign div_start = state_reg == ST_SEARCH && (stat.done || (seq_end_reg && !stat.busy))
                    && best_r != '0;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign out_load  = state_reg == ST_FINAL && out_free;

    assign w_r0 = pds_pkg::R0_BASE | (28'(best_n) << 12);
    assign w_r1 = pds_pkg::R1_BASE | 28'(best_r[RW-1:0] & RW'(8'hFF));
    assign w_r3 = (best_d > DW'(1)) ? (pds_pkg::R3_BASE | (28'((best_d - DW'(2)) >> 1) << 14))
                                    : pds_pkg::R3_BASE;
    assign w_r5 = pds_pkg::R5_BASE | ((best_d > DW'(1)) ? 28'h80 : 28'h0)
                | (28'(pds_pkg::band_code(ref_reg)) << 17);

    pds_eval #(.RW(RW), .NW(NW), .DW(DW)) u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .target     (eval_tgt),
        .cand_valid (issue),
        .cand_r     (r_reg),
        .cand_n     (n_reg),
        .cand_d     (d_reg),
        .cand_fn    (fn_cur),
        .stat       (stat),
        .best_r     (best_r),
        .best_n     (best_n),
        .best_d     (best_d)
    );

    pds_div #(.NUMW(FNW), .DENW(DENW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (FNW'(ref_reg) * FNW'(best_n)),
        .den   (DENW'(best_r) * DENW'(best_d)),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ref_reg       <= pds_pkg::REF_RESET;
            seq_end_reg   <= 1'b0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            r_reg         <= '0;
            n_reg         <= '0;
            d_reg         <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                ref_reg <= cfg_wr_data;
            if (m_axis_tready && !out_load)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        tgt_reg     <= s_axis_tdata;
                        r_reg       <= RW'(1);
                        n_reg       <= NW'(N_MAX);
                        d_reg       <= DW'(D_MAX);
                        seq_end_reg <= 1'b0;
                        fail_reg    <= !in_range;
                        state_reg   <= in_range ? ST_SEARCH : ST_FINAL;
                    end
                end
                ST_SEARCH:
                begin
                    if (stat.done || (seq_end_reg && !stat.busy))
                    begin
                        fail_reg  <= best_r == '0;
                        state_reg <= (best_r == '0) ? ST_FINAL : ST_DIVIDE;
                    end
                    else if (!seq_end_reg)
                    begin
                        // Walk R up, N down, D down by two and then to one.
                        if (pfd_bad || (vco_bad && n_reg == NW'(7))
                            || (!vco_bad && d_reg == DW'(1) && n_reg == NW'(7)))
                        begin
                            n_reg <= NW'(N_MAX);
                            d_reg <= DW'(D_MAX);
                            if (r_reg == RW'(R_MAX))
                                seq_end_reg <= 1'b1;
                            else
                                r_reg <= r_reg + 1'b1;
                        end
                        else if (vco_bad || d_reg == DW'(1))
                        begin
                            n_reg <= n_reg - 1'b1;
                            d_reg <= DW'(D_MAX);
                        end
                        else if (d_reg == DW'(2))
                            d_reg <= DW'(1);
                        else
                            d_reg <= d_reg - DW'(2);
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_done)
                    begin
                        ach_reg   <= div_quo[31:0];
                        state_reg <= ST_FINAL;
                    end
                end
                ST_FINAL:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        tuser_reg     <= fail_reg;
                        if (fail_reg)
                            tdata_reg <= '0;
                        else
                            tdata_reg <= {6'd0, w_r5, w_r3, w_r1, w_r0, ach_reg,
                                          6'(best_d), 12'(best_n), 8'(best_r)};
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

endmodule

>>> rtl/core/pds_checker.sv
// Port-level checks of the PLL divider search over time.
// Depends on pll_divider_search, to which it is bound.
module pds_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [175:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while one is in work");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("failure result carries nonzero fields");

    a_ok_dividers: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] != 8'd0
                                           && m_axis_tdata[25:20] != 6'd0)
        else $error("success result without dividers");

endmodule

bind pll_divider_search pds_checker u_pds_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
